[sv/qrs_pkg.sv]
// Shared constants for the quadratic root solver.
// No dependencies; used by quadratic_root_solver and qrs_div.
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

    // Default word and fraction widths of the Q format
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

endpackage

`default_nettype wire

[sv/qrs_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on qrs_pkg for the default widths.
`timescale 1ns / 1ps
`default_nettype none

module qrs_div #(
    parameter int NUM_W = qrs_pkg::WORD_BITS_DEF + 2 + qrs_pkg::FRAC_BITS_DEF,
    parameter int DEN_W = qrs_pkg::WORD_BITS_DEF + 1
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quo
);

    logic [NUM_W-1:0] num_reg [0:NUM_W-1];
    logic [DEN_W-1:0] den_reg [0:NUM_W-1];
    logic [DEN_W-1:0] rem_reg [0:NUM_W-1];
    logic [NUM_W-1:0] q_reg   [0:NUM_W-1];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [NUM_W-1:0] src_num;
        logic [DEN_W-1:0] src_den;
        logic [DEN_W-1:0] src_rem;
        logic [NUM_W-1:0] src_q;
        logic [DEN_W:0]   rem_sh;
        logic             ge;

        if (k == 0) begin : g_first
            assign src_num = num;
            assign src_den = den;
            assign src_rem = '0;
            assign src_q   = '0;
        end else begin : g_rest
            assign src_num = num_reg[k-1];
            assign src_den = den_reg[k-1];
            assign src_rem = rem_reg[k-1];
            assign src_q   = q_reg[k-1];
        end

        // shift in the next numerator bit and trial-subtract
        assign rem_sh = {src_rem, src_num[NUM_W-1-k]};
        assign ge     = (rem_sh >= (DEN_W+1)'(src_den));

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k] <= src_num;
                den_reg[k] <= src_den;
                rem_reg[k] <= ge ? DEN_W'(rem_sh - (DEN_W+1)'(src_den)) : DEN_W'(rem_sh);
                q_reg[k]   <= {src_q[NUM_W-2:0], ge};
            end
        end
    end

    assign quo = q_reg[NUM_W-1];

endmodule

`default_nettype wire

[sv/quadratic_root_solver.sv]
// Quadratic root solver, Q format fixed point, fully pipelined.
// Depends on qrs_pkg and qrs_div.
//
// Usage:
//   Input channel s_valid/s_ready carries coef_a, coef_b, coef_c per
//   transaction; result channel m_valid/m_ready carries both roots (real and
//   imaginary parts) and the complex, leading-zero and saturation flags.
//   One result transaction follows every input transaction, in order.
//   Throughput: one transaction per cycle, sustained while results are taken.
//   Pipeline: the square root pipeline (WORD_BITS+1 stages, one root bit
//   each) and the two parallel dividers (WORD_BITS+2+FRAC_BITS stages, one
//   quotient bit each), plus unpack, multiply, discriminant, numerator and
//   output stages.
//   Reset (aresetn low, synchronous) clears every stage's valid bit; payload
//   registers are not reset.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_ready drops; nothing is lost or repeated. Bubbles move through as
//   empty slots.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_root_solver #(
    parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [WORD_BITS-1:0] s_coef_a,
    input  wire logic [WORD_BITS-1:0] s_coef_b,
    input  wire logic [WORD_BITS-1:0] s_coef_c,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [WORD_BITS-1:0]      m_root1_real,
    output logic [WORD_BITS-1:0]      m_root2_real,
    output logic [WORD_BITS-1:0]      m_root1_imag,
    output logic [WORD_BITS-1:0]      m_root2_imag,
    output logic                      m_is_complex,
    output logic                      m_leading_zero,
    output logic                      m_saturated
);

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int RW   = W + 1;        // root width
    localparam int DW   = 2 * RW;       // discriminant magnitude width
    localparam int NW   = W + 2;        // numerator magnitude width
    localparam int QW   = NW + F;       // quotient width
    localparam int DENW = W + 1;        // 2a width

    typedef struct packed {
        logic         an;
        logic         bn;
        logic         lz;
        logic         dneg;
        logic [W-1:0] am;
        logic [W-1:0] bm;
    } sq_side_t;

    typedef struct packed {
        logic lz;
        logic cplx;
        logic neg_a;
        logic neg_b;
    } dv_side_t;

    logic adv;

    // whole pipeline moves when the output slot is free or being taken
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- stage 1: sign and magnitude ----------------
    logic         s1_valid_reg;
    logic         s1_an_reg, s1_bn_reg, s1_sx_reg;
    logic [W-1:0] s1_am_reg, s1_bm_reg, s1_cm_reg;
    logic         an_next, bn_next, cn_next;
    logic [W-1:0] am_next, bm_next, cm_next;

    always_comb begin
        am_next = s_coef_a[W-1] ? W'(-s_coef_a) : s_coef_a;
        bm_next = s_coef_b[W-1] ? W'(-s_coef_b) : s_coef_b;
        cm_next = s_coef_c[W-1] ? W'(-s_coef_c) : s_coef_c;
        an_next = s_coef_a[W-1];
        bn_next = s_coef_b[W-1];
        cn_next = s_coef_c[W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_valid;
        end
        if (adv) begin
            s1_an_reg <= an_next;
            s1_bn_reg <= bn_next;
            s1_sx_reg <= an_next ^ cn_next;
            s1_am_reg <= am_next;
            s1_bm_reg <= bm_next;
            s1_cm_reg <= cm_next;
        end
    end

    // ---------------- stage 2: products b*b and a*c ----------------
    logic           s2_valid_reg;
    logic [2*W-1:0] s2_bb_reg, s2_ac_reg;
    logic           s2_sx_reg;
    sq_side_t       s2_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (adv) begin
            s2_bb_reg        <= s1_bm_reg * s1_bm_reg;
            s2_ac_reg        <= s1_am_reg * s1_cm_reg;
            s2_sx_reg        <= s1_sx_reg;
            s2_side_reg.an   <= s1_an_reg;
            s2_side_reg.bn   <= s1_bn_reg;
            s2_side_reg.lz   <= (s1_am_reg == '0);
            s2_side_reg.dneg <= 1'b0;
            s2_side_reg.am   <= s1_am_reg;
            s2_side_reg.bm   <= s1_bm_reg;
        end
    end

    // ---------------- stage 3: discriminant b*b - 4ac ----------------
    logic [DW:0] disc_t;
    logic        dneg_next;
    logic [DW-1:0] dmag_next;
    sq_side_t    side_next;

    always_comb begin
        if (s2_sx_reg) begin
            disc_t = (DW+1)'(s2_bb_reg) + (DW+1)'({s2_ac_reg, 2'b00});
        end else begin
            disc_t = (DW+1)'(s2_bb_reg) - (DW+1)'({s2_ac_reg, 2'b00});
        end
        dneg_next = disc_t[DW];
        dmag_next = dneg_next ? DW'(-disc_t) : DW'(disc_t);
        side_next      = s2_side_reg;
        side_next.dneg = dneg_next;
    end

    logic           sq_valid_reg [0:RW];
    logic [DW-1:0]  sq_d_reg     [0:RW];
    logic [RW+1:0]  sq_rem_reg   [0:RW];
    logic [RW-1:0]  sq_root_reg  [0:RW];
    sq_side_t       sq_side_reg  [0:RW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_valid_reg[0] <= s2_valid_reg;
        end
        if (adv) begin
            sq_d_reg[0]    <= dmag_next;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_side_reg[0] <= side_next;
        end
    end

    // ---------------- square root: one root bit per stage ----------------
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        logic [RW+1:0] rem_sh;
        logic [RW+1:0] trial;
        logic          ge;

        assign rem_sh = {sq_rem_reg[k][RW-1:0], sq_d_reg[k][2*(RW-1-k)+1 -: 2]};
        assign trial  = {sq_root_reg[k], 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
            if (adv) begin
                sq_d_reg[k+1]    <= sq_d_reg[k];
                sq_rem_reg[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
                sq_root_reg[k+1] <= {sq_root_reg[k][RW-2:0], ge};
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // ---------------- numerators -b -/+ root, signs ----------------
    sq_side_t      sqo;
    logic [RW-1:0] root;
    logic [NW:0]   bext, rext, bt, t1, t2;
    logic [NW-1:0] na_next, nb_next;
    dv_side_t      nside_next;

    always_comb begin
        sqo  = sq_side_reg[RW];
        root = sq_root_reg[RW];
        bext = (NW+1)'(sqo.bm);
        rext = (NW+1)'(root);
        bt   = sqo.bn ? bext : (NW+1)'(-bext);
        t1   = bt - rext;
        t2   = bt + rext;
        nside_next.lz   = sqo.lz;
        nside_next.cplx = sqo.dneg;
        if (sqo.dneg) begin
            na_next          = NW'(sqo.bm);
            nb_next          = NW'(root);
            nside_next.neg_a = !sqo.bn ^ sqo.an;
            nside_next.neg_b = sqo.an;
        end else begin
            na_next          = t1[NW] ? NW'(-t1) : NW'(t1);
            nb_next          = t2[NW] ? NW'(-t2) : NW'(t2);
            nside_next.neg_a = t1[NW] ^ sqo.an;
            nside_next.neg_b = t2[NW] ^ sqo.an;
        end
    end

    logic            nm_valid_reg;
    logic [NW-1:0]   nm_a_reg, nm_b_reg;
    logic [DENW-1:0] nm_den_reg;
    dv_side_t        nm_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nm_valid_reg <= 1'b0;
        end else if (adv) begin
            nm_valid_reg <= sq_valid_reg[RW];
        end
        if (adv) begin
            nm_a_reg    <= na_next;
            nm_b_reg    <= nb_next;
            nm_den_reg  <= {sqo.am, 1'b0};
            nm_side_reg <= nside_next;
        end
    end

    // ---------------- two parallel dividers ----------------
    logic [QW-1:0] qa, qb;

    qrs_div #(.NUM_W(QW), .DEN_W(DENW)) u_div_a (
        .aclk (aclk),
        .en   (adv),
        .num  (QW'(nm_a_reg) << F),
        .den  (nm_den_reg),
        .quo  (qa)
    );

    qrs_div #(.NUM_W(QW), .DEN_W(DENW)) u_div_b (
        .aclk (aclk),
        .en   (adv),
        .num  (QW'(nm_b_reg) << F),
        .den  (nm_den_reg),
        .quo  (qb)
    );

    // sideband delay matching the divider depth
    logic     dv_valid_reg [0:QW-1];
    dv_side_t dv_side_reg  [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_dv_side
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k] <= 1'b0;
            end else if (adv) begin
                dv_valid_reg[k] <= (k == 0) ? nm_valid_reg : dv_valid_reg[(k == 0) ? 0 : k-1];
            end
            if (adv) begin
                dv_side_reg[k] <= (k == 0) ? nm_side_reg : dv_side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // ---------------- saturate and sign, output register ----------------
    // returns {clipped, value}
    function automatic logic [W:0] sat_fn(input logic [QW-1:0] q, input logic neg);
        logic [QW-1:0] lim;
        logic [QW-1:0] v;
        logic          clip;
        begin
            lim  = neg ? (QW'(1) << (W-1)) : ((QW'(1) << (W-1)) - QW'(1));
            clip = (q > lim);
            v    = clip ? lim : q;
            sat_fn = {clip, neg ? W'(-v[W-1:0]) : v[W-1:0]};
        end
    endfunction

    dv_side_t     dvo;
    logic [W:0]   sa, sb, sbn;
    logic [W-1:0] r1_next, r2_next, i1_next, i2_next;
    logic         sat_next;

    always_comb begin
        dvo = dv_side_reg[QW-1];
        sa  = sat_fn(qa, dvo.neg_a);
        sb  = sat_fn(qb, dvo.neg_b);
        sbn = sat_fn(qb, !dvo.neg_b);
        if (dvo.lz) begin
            r1_next  = '0;
            r2_next  = '0;
            i1_next  = '0;
            i2_next  = '0;
            sat_next = 1'b0;
        end else if (dvo.cplx) begin
            r1_next  = sa[W-1:0];
            r2_next  = sa[W-1:0];
            i1_next  = sbn[W-1:0];
            i2_next  = sb[W-1:0];
            sat_next = sa[W] | sb[W] | sbn[W];
        end else begin
            r1_next  = sa[W-1:0];
            r2_next  = sb[W-1:0];
            i1_next  = '0;
            i2_next  = '0;
            sat_next = sa[W] | sb[W];
        end
    end

    logic         m_valid_reg;
    logic [W-1:0] r1_reg, r2_reg, i1_reg, i2_reg;
    logic         cplx_reg, lz_reg, sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_valid_reg[QW-1];
        end
        if (adv) begin
            r1_reg   <= r1_next;
            r2_reg   <= r2_next;
            i1_reg   <= i1_next;
            i2_reg   <= i2_next;
            cplx_reg <= dvo.cplx & !dvo.lz;
            lz_reg   <= dvo.lz;
            sat_reg  <= sat_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_root1_real   = r1_reg;
    assign m_root2_real   = r2_reg;
    assign m_root1_imag   = i1_reg;
    assign m_root2_imag   = i2_reg;
    assign m_is_complex   = cplx_reg;
    assign m_leading_zero = lz_reg;
    assign m_saturated    = sat_reg;

endmodule

`default_nettype wire
